[rtl/core/adcavg_pkg.sv]
package adcavg_pkg;

	// converter sample and averaging group
	localparam int ADC_W     = 12;
	localparam int AVG_COUNT = 4;
	localparam int AVG_AW    = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
	localparam int AVG_PW    = $clog2(AVG_COUNT + 1);
	localparam int SSUM_W    = ADC_W + $clog2(AVG_COUNT);

	// millivolt conversion, rounded half up
	localparam int ADC_FULL_SCALE = 4096;
	localparam int MV_DEN         = 2 * ADC_FULL_SCALE;
	localparam int VREF_W         = 13;
	localparam int MV_W           = 13;
	localparam int MVP_W          = ADC_W + VREF_W + 2;

	// failure tracking
	localparam int FAIL_W  = 8;
	localparam int LIMIT_W = 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_VREF       = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT = 1'b1;
	localparam logic [VREF_W-1:0]    VREF_RESET     = 13'd3300;
	localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 8'd3;

	// item actions
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// averages window and stability score
	localparam int QUALITY_WINDOW = 8;
	localparam int WIN_DEPTH      = QUALITY_WINDOW;
	localparam int WIN_AW         = $clog2(WIN_DEPTH);
	localparam int FILL_W         = $clog2(WIN_DEPTH + 1);
	localparam int MIN_FILL       = 2;
	localparam int S_W            = ADC_W + WIN_AW;
	localparam int SQ_W           = 2 * ADC_W;
	localparam int QS_W           = SQ_W + WIN_AW;
	localparam int SS_W           = 2 * S_W;
	localparam int NQ_W           = QS_W + FILL_W;
	localparam int NN_W           = 2 * FILL_W;

	// variance thresholds are standard deviations squared
	localparam int STD_LO      = 5;
	localparam int STD_HI      = 20;
	localparam int LO_SQ       = STD_LO * STD_LO;
	localparam int HI_SQ       = STD_HI * STD_HI;
	localparam int SPAN        = HI_SQ - LO_SQ;
	localparam int SCORE_TOP   = 99;
	localparam int SCORE_SLOPE = 49;
	localparam int TH_W        = $clog2(HI_SQ * WIN_DEPTH * WIN_DEPTH + 1);
	localparam int NUM_W       = $clog2(SCORE_TOP * SPAN * WIN_DEPTH * WIN_DEPTH + 1);

	localparam int QUAL_W = 7;
	localparam int DIVC_W = $clog2(QUAL_W);
	localparam logic [QUAL_W-1:0] Q_ERROR  = 7'd0;
	localparam logic [QUAL_W-1:0] Q_NOISY  = 7'd10;
	localparam logic [QUAL_W-1:0] Q_FEW    = 7'd50;
	localparam logic [QUAL_W-1:0] Q_STABLE = 7'd100;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_SAMPLING = 2'd1,
		MODE_READY    = 2'd2,
		MODE_ERROR    = 2'd3
	} mode_t;

	typedef struct packed {
		logic             start;
		logic [ADC_W-1:0] avg;
	} score_req_t;

	typedef struct packed {
		logic              done;
		logic [QUAL_W-1:0] quality;
	} score_rsp_t;

endpackage

[rtl/core/adcavg_if.sv]
interface adcavg_in_if;
	import adcavg_pkg::*;

	logic       valid;
	logic       ready;
	logic       action;
	logic       read_ok;
	logic [7:0] high_byte;
	logic [7:0] low_byte;

	modport source (output valid, action, read_ok, high_byte, low_byte, input ready);
	modport sink (input valid, action, read_ok, high_byte, low_byte, output ready);
endinterface

interface adcavg_out_if;
	import adcavg_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [ADC_W-1:0]  average_raw;
	logic [MV_W-1:0]   millivolts;
	logic [QUAL_W-1:0] quality;
	logic              new_average;

	modport source (output valid, mode, average_raw, millivolts, quality, new_average,
		input ready);
	modport sink (input valid, mode, average_raw, millivolts, quality, new_average,
		output ready);
endinterface

[rtl/core/adcavg_score.sv]
module adcavg_score (
	input  logic                   clk,
	input  logic                   arst_n,
	input  adcavg_pkg::score_req_t req,
	output adcavg_pkg::score_rsp_t rsp
);
	import adcavg_pkg::*;

	typedef enum logic [6:0] {
		SC_IDLE  = 7'b0000001,
		SC_SUM   = 7'b0000010,
		SC_VAR   = 7'b0000100,
		SC_DIFF  = 7'b0001000,
		SC_RANGE = 7'b0010000,
		SC_PREP  = 7'b0100000,
		SC_DIV   = 7'b1000000
	} sc_state_t;

	sc_state_t state_q;

	logic [ADC_W-1:0]  win_mem [WIN_DEPTH];
	logic              wr_en;
	logic [WIN_AW-1:0] wpos_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] rcnt_q;

	logic [ADC_W-1:0]  rdata_s1;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [ADC_W-1:0]  val_s2;
	logic [SQ_W-1:0]   sq_s2;
	logic              vld_s2;
	logic              last_s2;

	logic [S_W-1:0]    s_acc_q;
	logic [QS_W-1:0]   q_acc_q;
	logic [SS_W-1:0]   ss_q;
	logic [NQ_W-1:0]   nq_q;
	logic [NN_W-1:0]   nn_q;
	logic [NQ_W-1:0]   d_q;
	logic [TH_W-1:0]   thr_lo;
	logic [TH_W-1:0]   thr_hi;
	logic [TH_W-1:0]   den_q;
	logic [TH_W-1:0]   dx_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic              rem_ge;
	logic [QUAL_W-1:0] quot_q;
	logic [QUAL_W-1:0] quot_next;
	logic [DIVC_W-1:0] k_q;

	logic              done_q;
	logic [QUAL_W-1:0] qual_q;

	assign wr_en    = (state_q == SC_IDLE) && req.start;
	assign fill_inc = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + 1'b1;

	assign thr_lo    = TH_W'(LO_SQ) * TH_W'(nn_q);
	assign thr_hi    = TH_W'(HI_SQ) * TH_W'(nn_q);
	assign rem_ge    = (rem_q >= dsh_q);
	assign quot_next = {quot_q[QUAL_W-2:0], rem_ge};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_mem[wpos_q] <= req.avg;
		end
		rdata_s1 <= win_mem[rcnt_q[WIN_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SC_IDLE;
			wpos_q     <= '0;
			fill_q     <= '0;
			rcnt_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			vld_s2     <= 1'b0;
			last_s2    <= 1'b0;
			k_q        <= '0;
			done_q     <= 1'b0;
			qual_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						wpos_q <= (wpos_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
						fill_q <= fill_inc;
						rcnt_q <= '0;
						if (fill_inc < FILL_W'(MIN_FILL)) begin
							done_q <= 1'b1;
							qual_q <= Q_FEW;
						end else begin
							state_q <= SC_SUM;
						end
					end
				end
				SC_SUM: begin
					// read -> square -> accumulate, one entry per cycle
					if (rcnt_q < fill_q) begin
						rd_vld_s1  <= 1'b1;
						rd_last_s1 <= (rcnt_q == fill_q - 1'b1);
						rcnt_q     <= rcnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					vld_s2  <= rd_vld_s1;
					last_s2 <= rd_vld_s1 && rd_last_s1;
					if (vld_s2 && last_s2) begin
						state_q <= SC_VAR;
					end
				end
				SC_VAR: begin
					state_q <= SC_DIFF;
				end
				SC_DIFF: begin
					state_q <= SC_RANGE;
				end
				SC_RANGE: begin
					if (d_q < NQ_W'(thr_lo)) begin
						done_q  <= 1'b1;
						qual_q  <= Q_STABLE;
						state_q <= SC_IDLE;
					end else if (d_q < NQ_W'(thr_hi)) begin
						state_q <= SC_PREP;
					end else begin
						done_q  <= 1'b1;
						qual_q  <= Q_NOISY;
						state_q <= SC_IDLE;
					end
				end
				SC_PREP: begin
					k_q     <= DIVC_W'(QUAL_W - 1);
					state_q <= SC_DIV;
				end
				SC_DIV: begin
					k_q <= k_q - 1'b1;
					if (k_q == '0) begin
						done_q  <= 1'b1;
						qual_q  <= quot_next;
						state_q <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= rdata_s1;
		sq_s2  <= SQ_W'(rdata_s1) * SQ_W'(rdata_s1);
		case (state_q)
			SC_IDLE: begin
				s_acc_q <= '0;
				q_acc_q <= '0;
			end
			SC_SUM: begin
				if (vld_s2) begin
					s_acc_q <= s_acc_q + S_W'(val_s2);
					q_acc_q <= q_acc_q + QS_W'(sq_s2);
				end
			end
			SC_VAR: begin
				ss_q <= SS_W'(s_acc_q) * SS_W'(s_acc_q);
				nq_q <= NQ_W'(fill_q) * NQ_W'(q_acc_q);
				nn_q <= NN_W'(fill_q) * NN_W'(fill_q);
			end
			SC_DIFF: begin
				// n*n times the variance, never negative
				d_q <= nq_q - NQ_W'(ss_q);
			end
			SC_RANGE: begin
				den_q <= TH_W'(SPAN) * TH_W'(nn_q);
				dx_q  <= TH_W'(d_q - NQ_W'(thr_lo));
			end
			SC_PREP: begin
				rem_q  <= NUM_W'(SCORE_TOP) * NUM_W'(den_q)
					- NUM_W'(SCORE_SLOPE) * NUM_W'(dx_q);
				dsh_q  <= NUM_W'(den_q) << (QUAL_W - 1);
				quot_q <= '0;
			end
			SC_DIV: begin
				// restoring division, one quotient bit per cycle
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q  <= dsh_q >> 1;
				quot_q <= quot_next;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done    = done_q;
	assign rsp.quality = qual_q;

endmodule

[rtl/core/adc_average_and_stability_score.sv]
// ADC averager with stability score.
//
// sample_ch carries one converter read per transfer (action, read_ok and the
// two received bytes) or a clear-error request. result_ch returns exactly one
// result per input transfer: mode, last average, millivolts, quality score
// and a flag marking a freshly completed average.
// vref_mv and fail_limit are written through cfg_we / cfg_idx / cfg_wdata; the
// user must write them only while the block is idle; it does not enforce this.
// millivolts always uses the current vref_mv. An item that does not close an
// averaging group passes through the emit state, and its result is loaded into
// the output register once that register is free. An item that closes a group
// walks the sample memory and then the window memory one entry per cycle; the
// restoring divider forms the interpolated score only between the thresholds,
// and the window walk is skipped while the window holds a single average.
// One item is in flight at a time; sample_ch.ready is high only while the
// controller is idle, and a new item is taken while a result still sits in
// the output register.
// Reset returns to idle with 3300 mV reference, fail limit 3, empty window,
// zero average and zero quality. When result_ch stalls, the output register
// holds its result and the next finished result waits in the controller.
module adc_average_and_stability_score (
	input  logic                              clk,
	input  logic                              arst_n,
	adcavg_in_if.sink                         sample_ch,
	adcavg_out_if.source                      result_ch,
	input  logic                              cfg_we,
	input  logic [adcavg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [adcavg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import adcavg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SUM   = 4'b0010,
		ST_SCORE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	logic [VREF_W-1:0]  vref_q;
	logic [LIMIT_W-1:0] limit_q;

	mode_t              mode_q;
	logic [FAIL_W-1:0]  fail_q;
	logic [FAIL_W-1:0]  fc_inc;
	logic [AVG_PW-1:0]  pos_q;
	logic [AVG_PW-1:0]  base_pos;
	logic [AVG_PW-1:0]  pos_inc;
	logic [ADC_W-1:0]   average_q;
	logic [QUAL_W-1:0]  quality_q;
	logic               fresh_q;

	logic               accept;
	logic               is_sample;
	logic               smp_we;
	logic [ADC_W-1:0]   raw;
	logic [ADC_W-1:0]   smp_mem [AVG_COUNT];
	logic [ADC_W-1:0]   smp_rdata_s1;
	logic [AVG_PW-1:0]  scnt_q;
	logic               srd_vld_s1;
	logic               srd_last_s1;
	logic [SSUM_W-1:0]  sacc_q;
	logic [SSUM_W-1:0]  sum_all;
	logic [ADC_W-1:0]   avg_new;

	logic               score_start_q;
	score_req_t         score_req;
	score_rsp_t         score_rsp;

	logic [MVP_W-1:0]   mv_prod;
	logic [MVP_W-1:0]   mv_full;
	logic               out_load;
	logic               out_vld_q;
	mode_t              o_mode_q;
	logic [ADC_W-1:0]   o_avg_q;
	logic [MV_W-1:0]    o_mv_q;
	logic [QUAL_W-1:0]  o_qual_q;
	logic               o_new_q;

	assign accept    = sample_ch.valid && sample_ch.ready;
	assign raw       = {sample_ch.high_byte[3:0], sample_ch.low_byte};
	assign is_sample = (sample_ch.action == ACT_SAMPLE) && (mode_q != MODE_ERROR);
	assign smp_we    = accept && is_sample && sample_ch.read_ok;
	// leaving idle restarts the group
	assign base_pos  = (mode_q == MODE_IDLE) ? '0 : pos_q;
	assign pos_inc   = base_pos + 1'b1;
	assign fc_inc    = (fail_q == '1) ? fail_q : fail_q + 1'b1;

	assign sum_all = sacc_q + SSUM_W'(smp_rdata_s1);
	assign avg_new = ADC_W'(sum_all / AVG_COUNT);

	assign mv_prod  = MVP_W'(average_q) * MVP_W'(vref_q);
	assign mv_full  = MVP_W'((mv_prod + mv_prod + MVP_W'(ADC_FULL_SCALE)) / MV_DEN);
	assign out_load = (state_q == ST_EMIT) && (!out_vld_q || result_ch.ready);

	assign sample_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vref_q  <= VREF_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VREF:       vref_q  <= cfg_wdata[VREF_W-1:0];
				REG_FAIL_LIMIT: limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (smp_we) begin
			smp_mem[base_pos[AVG_AW-1:0]] <= raw;
		end
		smp_rdata_s1 <= smp_mem[scnt_q[AVG_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_IDLE;
			fail_q        <= '0;
			pos_q         <= '0;
			average_q     <= '0;
			quality_q     <= '0;
			fresh_q       <= 1'b0;
			scnt_q        <= '0;
			srd_vld_s1    <= 1'b0;
			srd_last_s1   <= 1'b0;
			sacc_q        <= '0;
			score_start_q <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			score_start_q <= 1'b0;
			if (result_ch.ready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fresh_q <= 1'b0;
						scnt_q  <= '0;
						sacc_q  <= '0;
						state_q <= ST_EMIT;
						if (sample_ch.action == ACT_CLEAR) begin
							if (mode_q == MODE_ERROR) begin
								fail_q <= '0;
								mode_q <= MODE_IDLE;
								pos_q  <= '0;
							end
						end else if (is_sample) begin
							if (!sample_ch.read_ok) begin
								fail_q <= fc_inc;
								if (fc_inc >= limit_q) begin
									mode_q    <= MODE_ERROR;
									quality_q <= Q_ERROR;
								end
							end else begin
								fail_q <= '0;
								if (pos_inc >= AVG_PW'(AVG_COUNT)) begin
									pos_q   <= '0;
									fresh_q <= 1'b1;
									mode_q  <= MODE_READY;
									state_q <= ST_SUM;
								end else begin
									pos_q <= pos_inc;
									if (mode_q == MODE_IDLE) begin
										mode_q <= MODE_SAMPLING;
									end
								end
							end
						end
					end
				end
				ST_SUM: begin
					if (scnt_q < AVG_PW'(AVG_COUNT)) begin
						srd_vld_s1  <= 1'b1;
						srd_last_s1 <= (scnt_q == AVG_PW'(AVG_COUNT - 1));
						scnt_q      <= scnt_q + 1'b1;
					end else begin
						srd_vld_s1 <= 1'b0;
					end
					if (srd_vld_s1) begin
						sacc_q <= sum_all;
						if (srd_last_s1) begin
							average_q     <= avg_new;
							score_start_q <= 1'b1;
							state_q       <= ST_SCORE;
						end
					end
				end
				ST_SCORE: begin
					if (score_rsp.done) begin
						quality_q <= score_rsp.quality;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_mode_q <= mode_q;
			o_avg_q  <= average_q;
			o_mv_q   <= mv_full[MV_W-1:0];
			o_qual_q <= quality_q;
			o_new_q  <= fresh_q;
		end
	end

	assign score_req.start = score_start_q;
	assign score_req.avg   = average_q;

	adcavg_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (score_req),
		.rsp    (score_rsp)
	);

	assign result_ch.valid       = out_vld_q;
	assign result_ch.mode        = o_mode_q;
	assign result_ch.average_raw = o_avg_q;
	assign result_ch.millivolts  = o_mv_q;
	assign result_ch.quality     = o_qual_q;
	assign result_ch.new_average = o_new_q;

`ifndef ASSERT_OFF
	a_fresh_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.new_average |-> result_ch.mode == MODE_READY)
		else $error("fresh average reported outside ready mode");

	a_error_zero_quality: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.mode == MODE_ERROR |-> result_ch.quality == Q_ERROR)
		else $error("error mode with nonzero quality");

	a_score_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		score_rsp.done |-> state_q == ST_SCORE)
		else $error("score unit finished while controller was not waiting");

	a_group_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pos_q < AVG_PW'(AVG_COUNT))
		else $error("sample group position out of range");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import adcavg_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;

	typedef struct packed {
		logic       action;
		logic       read_ok;
		logic [7:0] high_byte;
		logic [7:0] low_byte;
	} sample_t;

	typedef struct packed {
		mode_t             mode;
		logic [ADC_W-1:0]  average_raw;
		logic [MV_W-1:0]   millivolts;
		logic [QUAL_W-1:0] quality;
		logic              new_average;
	} reading_t;

	typedef struct packed {
		sample_t  item;
		logic     known;
		reading_t want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	adcavg_in_if  sample_ch();
	adcavg_out_if result_ch();

	adc_average_and_stability_score uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// averager state as seen from outside
	mode_t             ctl_mode = MODE_IDLE;
	logic [7:0]        miss_run = '0;
	logic [ADC_W-1:0]  group_buf [AVG_COUNT] = '{default: '0};
	int                group_len = 0;
	logic [ADC_W-1:0]  last_avg = '0;
	logic [ADC_W-1:0]  avg_ring [QUALITY_WINDOW] = '{default: '0};
	int                ring_head = 0;
	int                ring_count = 0;
	logic [QUAL_W-1:0] score = '0;
	logic [VREF_W-1:0] vref_setting = VREF_RESET;
	logic [7:0]        miss_limit = LIMIT_RESET;

	reading_t pending_readings[$];
	int error_count = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int live_items = 0;
	int fail_burst = 0;
	int level_base = 2048;
	int level_spread = 0;

	step_row_t directed_rows [20] = '{
		'{'{ACT_CLEAR, 1'b0, 8'h00, 8'h00}, 1'b1, '{MODE_IDLE, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b0, 8'hFF, 8'hFF}, 1'b1, '{MODE_IDLE, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b0, 8'h00, 8'h00}, 1'b1, '{MODE_IDLE, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b0, 8'h5A, 8'hA5}, 1'b1, '{MODE_ERROR, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hFF, 8'hFF}, 1'b1, '{MODE_ERROR, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_CLEAR, 1'b0, 8'hFF, 8'hFF}, 1'b1, '{MODE_IDLE, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hFF, 8'hFF}, 1'b1, '{MODE_SAMPLING, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hFF, 8'hFF}, 1'b1, '{MODE_SAMPLING, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hFF, 8'hFF}, 1'b1, '{MODE_SAMPLING, 12'd0, 13'd0, 7'd0, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'h0F, 8'hFF}, 1'b1,
			'{MODE_READY, 12'd4095, 13'd3299, 7'd50, 1'b1}},
		'{'{ACT_SAMPLE, 1'b1, 8'hF0, 8'h00}, 1'b1,
			'{MODE_READY, 12'd4095, 13'd3299, 7'd50, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hF0, 8'h00}, 1'b1,
			'{MODE_READY, 12'd4095, 13'd3299, 7'd50, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'hF0, 8'h00}, 1'b1,
			'{MODE_READY, 12'd4095, 13'd3299, 7'd50, 1'b0}},
		'{'{ACT_SAMPLE, 1'b1, 8'h00, 8'h00}, 1'b1, '{MODE_READY, 12'd0, 13'd0, 7'd10, 1'b1}},
		'{'{ACT_SAMPLE, 1'b0, 8'h00, 8'h00}, 1'b0, '0},
		'{'{ACT_CLEAR, 1'b1, 8'hFF, 8'h00}, 1'b0, '0},
		'{'{ACT_SAMPLE, 1'b1, 8'hA5, 8'h5A}, 1'b0, '0},
		'{'{ACT_SAMPLE, 1'b1, 8'h5A, 8'hA5}, 1'b0, '0},
		'{'{ACT_SAMPLE, 1'b1, 8'h3C, 8'hC3}, 1'b0, '0},
		'{'{ACT_SAMPLE, 1'b1, 8'hC3, 8'h3C}, 1'b0, '0}
	};

	int spread_steps [9] = '{0, 3, 10, 20, 35, 50, 80, 300, 4095};

	// stability score from n*n times the variance of the ring, kept in integers
	function automatic logic [QUAL_W-1:0] ring_score();
		longint unsigned n, s, sq, d, nn, v;
		n = ring_count;
		s = 0;
		sq = 0;
		if (n < 2)
			return 7'd50;
		for (int i = 0; i < ring_count; i++) begin
			v = avg_ring[i];
			s += v;
			sq += v * v;
		end
		d = n * sq - s * s;
		nn = n * n;
		if (d < 25 * nn)
			return 7'd100;
		if (d < 400 * nn)
			return QUAL_W'((99 * 375 * nn - 49 * (d - 25 * nn)) / (375 * nn));
		return 7'd10;
	endfunction

	function automatic reading_t predict_reading(sample_t it);
		reading_t r;
		logic [ADC_W-1:0] raw;
		int sum;
		longint unsigned mv;
		raw = {it.high_byte[3:0], it.low_byte};
		r.new_average = 1'b0;
		if (it.action == ACT_CLEAR) begin
			if (ctl_mode == MODE_ERROR) begin
				miss_run = '0;
				ctl_mode = MODE_IDLE;
				group_len = 0;
			end
		end else if (ctl_mode != MODE_ERROR) begin
			if (!it.read_ok) begin
				if (miss_run != 8'hFF)
					miss_run++;
				if (miss_run >= miss_limit) begin
					ctl_mode = MODE_ERROR;
					score = '0;
				end
			end else begin
				miss_run = '0;
				if (ctl_mode == MODE_IDLE) begin
					ctl_mode = MODE_SAMPLING;
					group_len = 0;
				end
				group_buf[group_len] = raw;
				group_len++;
				if (group_len >= AVG_COUNT) begin
					sum = 0;
					for (int i = 0; i < AVG_COUNT; i++)
						sum += group_buf[i];
					last_avg = ADC_W'(sum / AVG_COUNT);
					avg_ring[ring_head] = last_avg;
					ring_head = (ring_head + 1) % QUALITY_WINDOW;
					if (ring_count < QUALITY_WINDOW)
						ring_count++;
					score = ring_score();
					if (ctl_mode == MODE_SAMPLING)
						ctl_mode = MODE_READY;
					group_len = 0;
					r.new_average = 1'b1;
				end
			end
		end
		mv = (longint'(last_avg) * vref_setting * 2 + ADC_FULL_SCALE) / (2 * ADC_FULL_SCALE);
		r.mode = ctl_mode;
		r.average_raw = last_avg;
		r.millivolts = MV_W'(mv);
		r.quality = score;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		if (error_count < 100)
			$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic send_item(input sample_t it, input logic known, input reading_t typed);
		int gap;
		mode_t prior;
		reading_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				sample_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.action <= it.action;
		sample_ch.read_ok <= it.read_ok;
		sample_ch.high_byte <= it.high_byte;
		sample_ch.low_byte <= it.low_byte;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		prior = ctl_mode;
		r = predict_reading(it);
		pending_readings.push_back(known ? typed : r);
		// samples dropped in error do not count as real work
		if (!(prior == MODE_ERROR && it.action == ACT_SAMPLE))
			live_items++;
	endtask

	function automatic sample_t next_random_item();
		sample_t it;
		int pick, v;
		it.action = ACT_SAMPLE;
		it.read_ok = 1'b1;
		it.high_byte = 8'($urandom);
		it.low_byte = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (fail_burst > 0) begin
			fail_burst--;
			it.read_ok = 1'b0;
		end else if (ctl_mode == MODE_ERROR && pick < 60) begin
			it.action = ACT_CLEAR;
		end else if (pick < 80) begin
			v = level_base + int'($urandom_range(0, 2 * level_spread)) - level_spread;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			it.high_byte[3:0] = v[11:8];
			it.low_byte = v[7:0];
		end else if (pick < 87) begin
			it.read_ok = 1'b0;
		end else if (pick < 91) begin
			it.action = ACT_CLEAR;
		end else if (pick < 92) begin
			// run of failures long enough to reach the limit
			fail_burst = int'(miss_limit) + $urandom_range(0, 2);
			it.read_ok = 1'b0;
		end else begin
			it.action = 1'($urandom);
			it.read_ok = 1'($urandom);
		end
		return it;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_VREF)
			vref_setting = val;
		else
			miss_limit = val[7:0];
	endtask

	task automatic quiesce();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_readings.size() == 0) begin
				flag_error("result transfer with nothing pending");
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.mode !== want.mode)
					flag_error($sformatf("mode got %0d want %0d", result_ch.mode, want.mode));
				if (result_ch.average_raw !== want.average_raw)
					flag_error($sformatf("average_raw got %0d want %0d",
						result_ch.average_raw, want.average_raw));
				if (result_ch.millivolts !== want.millivolts)
					flag_error($sformatf("millivolts got %0d want %0d",
						result_ch.millivolts, want.millivolts));
				if (result_ch.quality !== want.quality)
					flag_error($sformatf("quality got %0d want %0d",
						result_ch.quality, want.quality));
				if (result_ch.new_average !== want.new_average)
					flag_error($sformatf("new_average got %0d want %0d",
						result_ch.new_average, want.new_average));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: stall patterns, plus one long hold-off to back up the input
	initial begin : result_sink
		int style, span;
		bit held;
		held = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					result_ch.ready <= 1'b0;
				end
			end
			style = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (style)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom);
					2: result_ch.ready <= ($urandom_range(0, 9) != 0);
					default: result_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int sent;
		logic [CFG_DATA_W-1:0] vref_val, limit_val;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.action = ACT_SAMPLE;
		sample_ch.read_ok = 1'b0;
		sample_ch.high_byte = '0;
		sample_ch.low_byte = '0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows run at the reset settings
		for (int i = 0; i < $size(directed_rows); i++)
			send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);

		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			case (p)
				0: begin vref_val = 13'd5000; limit_val = 13'd255; end
				1: begin vref_val = 13'd0;    limit_val = 13'd1;   end
				2: begin vref_val = 13'd3300; limit_val = 13'd0;   end
				3: begin vref_val = 13'd4096; limit_val = 13'd2;   end
				4: begin vref_val = 13'd1;    limit_val = 13'd3;   end
				default: begin
					vref_val = CFG_DATA_W'($urandom_range(0, 5000));
					limit_val = CFG_DATA_W'($urandom_range(1, 255));
				end
			endcase
			write_reg(REG_VREF, vref_val);
			write_reg(REG_FAIL_LIMIT, limit_val);
			fail_burst = 0;
			live_items = 0;
			sent = 0;
			while (live_items < PHASE_ITEMS) begin
				// new signal level and noise spread every so often
				if (sent % 40 == 0) begin
					level_spread = spread_steps[$urandom_range(0, 8)];
					level_base = $urandom_range(0, 4095);
					if ($urandom_range(0, 4) == 0)
						level_base = $urandom_range(0, 1) ? 4095 : 0;
				end
				send_item(next_random_item(), 1'b0, '0);
				sent++;
			end
		end

		quiesce();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/adcavg_pkg.sv
rtl/core/adcavg_if.sv
rtl/core/adcavg_score.sv
rtl/core/adc_average_and_stability_score.sv
dv/testbench.sv
